FILE: hw/rtl/aks_pkg.sv
// aks_pkg: shared types, constants and functions of the key schedule block
// used by the interfaces, front, queue and back modules; no dependencies
package aks_pkg;

  // default sizes
  localparam int MAX_KEY_WORDS_DEF      = 8;
  localparam int MAX_SCHEDULE_WORDS_DEF = 60;

  // field widths
  localparam int WORD_W  = 32;
  localparam int IDX_W   = 6;
  localparam int KW_W    = 4;
  localparam int SCHED_W = 6;
  localparam int END_W   = 7;
  localparam int CFG_W   = 6;
  localparam int CFG_IDX_W = 1;

  // request queue depth
  localparam int Q_DEPTH = 4;

  // a schedule ends at most this many words, less one, past the key words
  localparam int RESULT_LIMIT = 53;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORDS      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCHEDULE_WORDS = 1'd1;

  // reset values, key length limits and the SubWord-only slot selection
  localparam logic [KW_W-1:0]    KEY_WORDS_RST      = 4'd4;
  localparam logic [SCHED_W-1:0] SCHEDULE_WORDS_RST = 6'd44;
  localparam logic [KW_W-1:0]    MIN_KEY_WORDS      = 4'd4;
  localparam logic [KW_W-1:0]    SUBONLY_ABOVE      = 4'd6;
  localparam logic [KW_W-1:0]    SUBONLY_SLOT       = 4'd4;

  // round constant start value and its reduction polynomial
  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [7:0] GF_POLY   = 8'h1b;

  // back state
  typedef enum logic {
    ST_ECHO,
    ST_EXPAND
  } aks_state_t;

  // one queue entry: a key word and what follows it
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  idx;
    logic              last;
    logic              expand;
  } aks_job_t;

  // effective configuration handed to the back
  typedef struct packed {
    logic [KW_W-1:0]  kw;
    logic [END_W-1:0] end_words;
  } aks_cfg_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // s-box on each byte of a word
  function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // rotate left by one byte
  function automatic logic [WORD_W-1:0] rot_word(input logic [WORD_W-1:0] w);
    return {w[23:0], w[31:24]};
  endfunction

  // multiply by x in gf(2^8)
  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
  endfunction

endpackage

FILE: hw/rtl/aks_if.sv
// aks_if: valid/ready channel interfaces for key words and round-key words
// depends on aks_pkg for field widths
interface aks_in_if;
  logic                         valid;
  logic                         ready;
  logic [aks_pkg::WORD_W-1:0]   key_word;

  modport source (output valid, output key_word, input ready);
  modport sink   (input valid, input key_word, output ready);
endinterface

interface aks_out_if;
  logic                         valid;
  logic                         ready;
  logic [aks_pkg::WORD_W-1:0]   round_key_word;
  logic [aks_pkg::IDX_W-1:0]    word_index;
  logic                         last;

  modport source (output valid, output round_key_word, output word_index, output last,
                  input ready);
  modport sink   (input valid, input round_key_word, input word_index, input last,
                  output ready);
endinterface

FILE: hw/rtl/aks_front.sv
// aks_front: configuration registers and key word intake, classifies each
// request and pushes it into the queue; depends on aks_pkg and aks_if
module aks_front #(
  parameter int MAX_KEY_WORDS      = aks_pkg::MAX_KEY_WORDS_DEF,
  parameter int MAX_SCHEDULE_WORDS = aks_pkg::MAX_SCHEDULE_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [aks_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aks_pkg::CFG_W-1:0]       cfg_data,
  aks_in_if.sink                          in_req,
  input  logic                            q_full,
  output logic                            q_push,
  output aks_pkg::aks_job_t               q_job,
  output aks_pkg::aks_cfg_t               cfg
);

  logic [aks_pkg::KW_W-1:0]    key_words_r, key_words_nxt;
  logic [aks_pkg::SCHED_W-1:0] sched_r, sched_nxt;
  logic [aks_pkg::KW_W-1:0]    done_r, done_nxt;
  logic [aks_pkg::KW_W-1:0]    kw;
  logic [aks_pkg::END_W-1:0]   end_words;
  logic [aks_pkg::END_W-1:0]   end_lim;
  logic [aks_pkg::KW_W-1:0]    idx;
  logic                        key_end;
  logic                        accept;

  // clamp key length to the supported range
  always_comb begin
    if (key_words_r < aks_pkg::MIN_KEY_WORDS) begin
      kw = aks_pkg::MIN_KEY_WORDS;
    end else if (key_words_r > aks_pkg::KW_W'(MAX_KEY_WORDS)) begin
      kw = aks_pkg::KW_W'(MAX_KEY_WORDS);
    end else begin
      kw = key_words_r;
    end
  end

  // schedule end, bounded by storage and by the longest burst
  always_comb begin
    end_lim   = aks_pkg::END_W'(kw) + aks_pkg::END_W'(aks_pkg::RESULT_LIMIT - 1);
    end_words = {1'b0, sched_r};
    if (end_words > aks_pkg::END_W'(MAX_SCHEDULE_WORDS)) begin
      end_words = aks_pkg::END_W'(MAX_SCHEDULE_WORDS);
    end
    if (end_words > end_lim) begin
      end_words = end_lim;
    end
  end

  assign cfg.kw        = kw;
  assign cfg.end_words = end_words;

  // classify the incoming key word
  assign in_req.ready = !q_full;
  assign accept       = in_req.valid && !q_full;
  assign idx          = (done_r >= kw) ? kw - 1'b1 : done_r;
  assign key_end      = (idx + 1'b1) == kw;

  assign q_push     = accept;
  assign q_job.word = in_req.key_word;
  assign q_job.idx  = aks_pkg::IDX_W'(idx);
  assign q_job.last = key_end && (end_words <= aks_pkg::END_W'(kw));
  assign q_job.expand = key_end && (end_words > aks_pkg::END_W'(kw));

  // register writes and intake count
  always_comb begin
    key_words_nxt = key_words_r;
    sched_nxt     = sched_r;
    done_nxt      = done_r;
    if (accept) begin
      done_nxt = key_end ? '0 : idx + 1'b1;
    end
    if (cfg_we) begin
      case (cfg_index)
        aks_pkg::REG_KEY_WORDS: begin
          key_words_nxt = cfg_data[aks_pkg::KW_W-1:0];
          done_nxt      = '0;
        end
        aks_pkg::REG_SCHEDULE_WORDS: begin
          sched_nxt = cfg_data[aks_pkg::SCHED_W-1:0];
          done_nxt  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_words_r <= aks_pkg::KEY_WORDS_RST;
      sched_r     <= aks_pkg::SCHEDULE_WORDS_RST;
      done_r      <= '0;
    end else begin
      key_words_r <= key_words_nxt;
      sched_r     <= sched_nxt;
      done_r      <= done_nxt;
    end
  end

endmodule

FILE: hw/rtl/aks_queue.sv
// aks_queue: short request queue between front and back
// depends on aks_pkg for the entry type and depth
module aks_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  aks_pkg::aks_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              avail,
  output aks_pkg::aks_job_t pop_job
);

  localparam int PTR_W = $clog2(aks_pkg::Q_DEPTH);
  localparam int CNT_W = $clog2(aks_pkg::Q_DEPTH + 1);

  aks_pkg::aks_job_t  mem_r [aks_pkg::Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full    = cnt_r == CNT_W'(aks_pkg::Q_DEPTH);
  assign avail   = cnt_r != '0;
  assign pop_job = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: hw/rtl/aks_back.sv
// aks_back: echoes key words, expands the schedule one word per cycle while out_res
// is ready, holds the word window and the output register; depends on aks_pkg, aks_if
module aks_back #(
  parameter int MAX_KEY_WORDS = aks_pkg::MAX_KEY_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  aks_pkg::aks_cfg_t cfg,
  input  logic              q_avail,
  input  aks_pkg::aks_job_t q_job,
  output logic              q_pop,
  aks_out_if.source         out_res
);

  localparam int SLOT_W = $clog2(MAX_KEY_WORDS + 1);

  aks_pkg::aks_state_t          state_r, state_nxt;
  logic [aks_pkg::WORD_W-1:0]   win_r [MAX_KEY_WORDS];
  logic [aks_pkg::WORD_W-1:0]   win_nxt [MAX_KEY_WORDS];
  logic [aks_pkg::WORD_W-1:0]   prev_r;
  logic [7:0]                   rcon_r;
  logic [aks_pkg::IDX_W-1:0]    idx_r;
  logic [SLOT_W-1:0]            slot_r;
  logic                         out_valid_r;
  logic [aks_pkg::WORD_W-1:0]   out_word_r;
  logic [aks_pkg::IDX_W-1:0]    out_idx_r;
  logic                         out_last_r;

  logic                         load_ok;
  logic                         load;
  logic                         gen;
  logic [aks_pkg::WORD_W-1:0]   ld_word;
  logic [aks_pkg::IDX_W-1:0]    ld_idx;
  logic                         ld_last;
  logic [aks_pkg::WORD_W-1:0]   temp;
  logic [aks_pkg::WORD_W-1:0]   gen_word;
  logic                         gen_last;
  logic [SLOT_W-1:0]            kw_s;
  logic [SLOT_W-1:0]            kw_m1;

  assign kw_s    = SLOT_W'(cfg.kw);
  assign kw_m1   = kw_s - 1'b1;
  assign load_ok = !out_valid_r || out_res.ready;

  // next schedule word from the newest and oldest words of the window
  always_comb begin
    temp = prev_r;
    if (slot_r == '0) begin
      temp = aks_pkg::sub_word(aks_pkg::rot_word(prev_r)) ^ {rcon_r, 24'h000000};
    end else if (cfg.kw > aks_pkg::SUBONLY_ABOVE &&
                 slot_r == SLOT_W'(aks_pkg::SUBONLY_SLOT)) begin
      temp = aks_pkg::sub_word(prev_r);
    end
    gen_word = win_r[0] ^ temp;
    gen_last = ({1'b0, idx_r} + 1'b1) == cfg.end_words;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aks_pkg::ST_ECHO: begin
        if (q_avail && load_ok && q_job.expand) begin
          state_nxt = aks_pkg::ST_EXPAND;
        end
      end
      aks_pkg::ST_EXPAND: begin
        if (load_ok && gen_last) begin
          state_nxt = aks_pkg::ST_ECHO;
        end
      end
      default: state_nxt = aks_pkg::ST_ECHO;
    endcase
  end

  // state outputs: what goes into the output register
  always_comb begin
    q_pop   = 1'b0;
    load    = 1'b0;
    gen     = 1'b0;
    ld_word = q_job.word;
    ld_idx  = q_job.idx;
    ld_last = q_job.last;
    case (state_r)
      aks_pkg::ST_ECHO: begin
        if (q_avail && load_ok) begin
          q_pop = 1'b1;
          load  = 1'b1;
        end
      end
      aks_pkg::ST_EXPAND: begin
        if (load_ok) begin
          gen     = 1'b1;
          load    = 1'b1;
          ld_word = gen_word;
          ld_idx  = idx_r;
          ld_last = gen_last;
        end
      end
      default: ;
    endcase
  end

  // window shifts toward entry zero, new word enters at key length minus one
  always_comb begin
    for (int k = 0; k < MAX_KEY_WORDS - 1; k++) begin
      if (SLOT_W'(k) < kw_m1) begin
        win_nxt[k] = win_r[k+1];
      end else if (SLOT_W'(k) == kw_m1) begin
        win_nxt[k] = ld_word;
      end else begin
        win_nxt[k] = win_r[k];
      end
    end
    if (SLOT_W'(MAX_KEY_WORDS - 1) == kw_m1) begin
      win_nxt[MAX_KEY_WORDS-1] = ld_word;
    end else begin
      win_nxt[MAX_KEY_WORDS-1] = win_r[MAX_KEY_WORDS-1];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aks_pkg::ST_ECHO;
      out_valid_r <= 1'b0;
      rcon_r      <= aks_pkg::RCON_INIT;
      idx_r       <= '0;
      slot_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop && q_job.expand) begin
        idx_r  <= aks_pkg::IDX_W'(cfg.kw);
        slot_r <= '0;
        rcon_r <= aks_pkg::RCON_INIT;
      end else if (gen) begin
        idx_r  <= idx_r + 1'b1;
        slot_r <= (slot_r == kw_m1) ? '0 : slot_r + 1'b1;
        if (slot_r == '0) begin
          rcon_r <= aks_pkg::gf_double(rcon_r);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r <= ld_word;
      out_idx_r  <= ld_idx;
      out_last_r <= ld_last;
      prev_r     <= ld_word;
      win_r      <= win_nxt;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.round_key_word = out_word_r;
  assign out_res.word_index     = out_idx_r;
  assign out_res.last           = out_last_r;

endmodule

FILE: hw/rtl/aks_key_schedule_core.sv
// aes_key_schedule_core: top level of the key schedule block
// depends on aks_pkg, aks_if, aks_front, aks_queue and aks_back
//
// Usage:
//   Set key_words (index 0) and schedule_words (index 1) on the cfg port while
//   the block is idle; either write restarts key intake.
//   Send the cipher key on in_req, one 32-bit word per request, first key byte
//   in bits 31..24. Each key word comes back on out_res as schedule word i.
//   After the last key word the block produces the remaining schedule words in
//   order; last marks the final word, and intake then starts a new key.
// Data path and throughput:
//   An accepted request is written to a queue entry and then loaded into the
//   output register, where it is valid on out_res. Key words pass at one per
//   cycle while out_res is ready and no expansion runs; expansion makes one
//   word per cycle while out_res is ready; an AES-128 key gives 44 words, AES-256 60.
// Reset and stalls:
//   Reset sets key_words to 4, schedule_words to 44 and empties the queue.
//   When out_res stalls, expansion pauses, the queue fills with further key
//   words and in_req.ready drops once it is full.
module aes_key_schedule_core #(
  parameter int MAX_KEY_WORDS      = aks_pkg::MAX_KEY_WORDS_DEF,
  parameter int MAX_SCHEDULE_WORDS = aks_pkg::MAX_SCHEDULE_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [aks_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aks_pkg::CFG_W-1:0]       cfg_data,
  aks_in_if.sink                          in_req,
  aks_out_if.source                       out_res
);

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_avail;
  aks_pkg::aks_job_t push_job;
  aks_pkg::aks_job_t pop_job;
  aks_pkg::aks_cfg_t cfg;

  // intake and configuration
  aks_front #(
    .MAX_KEY_WORDS      (MAX_KEY_WORDS),
    .MAX_SCHEDULE_WORDS (MAX_SCHEDULE_WORDS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (in_req),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job),
    .cfg       (cfg)
  );

  // request queue
  aks_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_job  (pop_job)
  );

  // echo and expansion
  aks_back #(
    .MAX_KEY_WORDS (MAX_KEY_WORDS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_avail (q_avail),
    .q_job   (pop_job),
    .q_pop   (q_pop),
    .out_res (out_res)
  );

endmodule

FILE: tb/aes_key_schedule_core_test.sv
// aes_key_schedule_core_test: self-checking bench for the streaming key expansion block
// predicts every round-key word from the accepted key words, with random stalls on both sides
// depends on aks_pkg, aks_if and aes_key_schedule_core
module aes_key_schedule_core_test;
  import aks_pkg::*;

  // one round-key word as the block reports it
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  pos;
    logic              last;
  } round_key_t;

  // key expansion predictor and the round-key words still due
  class key_expander;
    logic [KW_W-1:0]    key_words;
    logic [SCHED_W-1:0] schedule_words;
    logic [WORD_W-1:0]  window [MAX_KEY_WORDS_DEF];
    int unsigned        words_in;
    logic [7:0]         rcon;
    round_key_t         due_words [$];
    int                 faults;

    function new();
      key_words      = KEY_WORDS_RST;
      schedule_words = SCHEDULE_WORDS_RST;
      words_in       = 0;
      rcon           = RCON_INIT;
      faults         = 0;
    endfunction

    function logic [WORD_W-1:0] sbox_word(logic [WORD_W-1:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function logic [7:0] xtime(logic [7:0] b);
      logic [7:0] r;
      r = b << 1;
      if (b[7]) r = r ^ 8'h1b;
      return r;
    endfunction

    // effective key length, clamped to 4..8
    function int unsigned key_len();
      if (key_words < MIN_KEY_WORDS) return MIN_KEY_WORDS;
      if (key_words > MAX_KEY_WORDS_DEF) return MAX_KEY_WORDS_DEF;
      return key_words;
    endfunction

    // any register write restarts key intake
    function void write_reg(logic [CFG_IDX_W-1:0] r, logic [CFG_W-1:0] v);
      if (r == REG_KEY_WORDS) key_words = v[KW_W-1:0];
      else if (r == REG_SCHEDULE_WORDS) schedule_words = v[SCHED_W-1:0];
      else return;
      words_in = 0;
      rcon     = RCON_INIT;
    endfunction

    function void push_word(logic [WORD_W-1:0] w, int unsigned pos, bit last);
      round_key_t r;
      r.word = w;
      r.pos  = pos[IDX_W-1:0];
      r.last = last;
      due_words.push_back(r);
    endfunction

    // accepted key word: echo it, and expand once the key is complete
    function void take_key_word(logic [WORD_W-1:0] w);
      int unsigned nk, stop, pos, slot, i;
      logic [WORD_W-1:0] t, nw;
      nk   = key_len();
      stop = schedule_words;
      if (stop > MAX_SCHEDULE_WORDS_DEF) stop = MAX_SCHEDULE_WORDS_DEF;
      if (stop > nk + RESULT_LIMIT - 1) stop = nk + RESULT_LIMIT - 1;
      pos = words_in;
      if (pos >= nk) pos = nk - 1;
      window[pos] = w;
      push_word(w, pos, (pos + 1 == nk) && (stop <= nk));
      words_in = (pos + 1) & 63;
      if (words_in < nk) return;
      slot = 0;
      for (i = nk; i < stop; i++) begin
        t = window[(slot == 0) ? nk - 1 : slot - 1];
        if (slot == 0) begin
          t    = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
          rcon = xtime(rcon);
        end else if (nk > SUBONLY_ABOVE && slot == SUBONLY_SLOT) begin
          t = sbox_word(t);
        end
        nw = window[slot] ^ t;
        window[slot] = nw;
        push_word(nw, i, i + 1 == stop);
        slot++;
        if (slot == nk) slot = 0;
      end
      words_in = 0;
      rcon     = RCON_INIT;
    endfunction

    // compare one accepted round-key word with the oldest one due
    function void check_round_key(logic [WORD_W-1:0] w, logic [IDX_W-1:0] pos, logic last);
      round_key_t e;
      if (due_words.size() == 0) begin
        $error("unexpected round-key word %h at index %0d", w, pos);
        faults++;
        return;
      end
      e = due_words.pop_front();
      if (e.word !== w) begin
        $error("round_key_word: expected %h, got %h", e.word, w);
        faults++;
      end
      if (e.pos !== pos) begin
        $error("word_index: expected %0d, got %0d", e.pos, pos);
        faults++;
      end
      if (e.last !== last) begin
        $error("last: expected %b, got %b", e.last, last);
        faults++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  aks_in_if  key_ch ();
  aks_out_if round_ch ();

  key_expander expander = new();

  int unsigned sent_words;
  int unsigned cur_key_words;
  bit          quiet_tail;
  bit          stall_request;

  aes_key_schedule_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (key_ch),
    .out_res   (round_ch)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // observe config writes, accepted key words and accepted round-key words
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) expander.write_reg(cfg_index, cfg_data);
      if (key_ch.valid && key_ch.ready) expander.take_key_word(key_ch.key_word);
      if (round_ch.valid && round_ch.ready)
        expander.check_round_key(round_ch.round_key_word, round_ch.word_index, round_ch.last);
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin : result_sink
    bit held;
    held = 1'b0;
    round_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request && !held) begin
        held = 1'b1;
        round_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        round_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      round_ch.ready <= 1'b1;
    end
  end

  // offer one key word and wait for it to be taken; may leave a gap after it
  task automatic send_key_word(input logic [WORD_W-1:0] w);
    key_ch.valid    <= 1'b1;
    key_ch.key_word <= w;
    do @(posedge clk); while (!key_ch.ready);
    sent_words++;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      key_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // stop offering, wait for every due word, then allow the pipeline to settle
  task automatic drain();
    key_ch.valid <= 1'b0;
    while (expander.due_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write the selected registers back to back
  task automatic configure(input logic [KW_W-1:0] kw, input logic [SCHED_W-1:0] sched,
                           input bit set_kw, input bit set_sched);
    if (set_kw) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_KEY_WORDS;
      cfg_data  <= CFG_W'(kw);
      cur_key_words = kw;
      @(posedge clk);
    end
    if (set_sched) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_SCHEDULE_WORDS;
      cfg_data  <= sched;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic int unsigned clamp_kw(int unsigned kw);
    if (kw < MIN_KEY_WORDS) return MIN_KEY_WORDS;
    if (kw > MAX_KEY_WORDS_DEF) return MAX_KEY_WORDS_DEF;
    return kw;
  endfunction

  // random key word with some bias toward edge patterns
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_key(input int unsigned n);
    repeat (n) send_key_word(pick_word());
  endtask

  // run limit
  initial begin : watchdog
    #15_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int unsigned phase, nkeys, nk, kw, sched;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_KEY_WORDS;
    cfg_data        <= '0;
    key_ch.valid    <= 1'b0;
    key_ch.key_word <= '0;
    sent_words    = 0;
    cur_key_words = KEY_WORDS_RST;
    quiet_tail    = 1'b0;
    stall_request = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: aes-128 standard key, then all zeros and all ones
    send_key_word(32'h2b7e1516);
    send_key_word(32'h28aed2a6);
    send_key_word(32'habf71588);
    send_key_word(32'h09cf4f3c);
    repeat (4) send_key_word('0);
    repeat (4) send_key_word('1);
    drain();

    // aes-256 standard key, full 60-word schedule
    configure(4'd8, 6'd60, 1'b1, 1'b1);
    send_key_word(32'h603deb10);
    send_key_word(32'h15ca71be);
    send_key_word(32'h2b73aef0);
    send_key_word(32'h857d7781);
    send_key_word(32'h1f352c07);
    send_key_word(32'h3b6108d7);
    send_key_word(32'h2d9810a3);
    send_key_word(32'h0914dff4);
    drain();

    // key length below four and an empty schedule: echo only
    configure(4'd0, 6'd0, 1'b1, 1'b1);
    send_random_key(4);

    // random phases of mostly complete keys
    phase = 0;
    while (sent_words < 360) begin
      drain();
      phase++;
      if (sent_words >= 300) quiet_tail = 1'b1;
      case (phase)
        1: configure(4'd15, 6'd63, 1'b1, 1'b1);
        2: configure(4'd7, 6'd60, 1'b1, 1'b1);
        3: configure(4'd4, 6'd44, 1'b1, 1'b1);
        default: begin
          case ($urandom_range(0, 9))
            0, 1, 2: kw = 4;
            3, 4:    kw = 6;
            5, 6:    kw = 8;
            7:       kw = $urandom_range(0, 3);
            8:       kw = $urandom_range(9, 15);
            default: kw = ($urandom_range(0, 1) != 0) ? 5 : 7;
          endcase
          case ($urandom_range(0, 7))
            0, 1:    sched = 4 * (clamp_kw(kw) + 7);
            2:       sched = 63;
            3:       sched = $urandom_range(0, clamp_kw(kw));
            4:       sched = 60;
            default: sched = $urandom_range(0, 63);
          endcase
          case ($urandom_range(0, 5))
            0:       configure(KW_W'(kw), SCHED_W'(sched), 1'b1, 1'b0);
            1:       configure(KW_W'(kw), SCHED_W'(sched), 1'b0, 1'b1);
            default: configure(KW_W'(kw), SCHED_W'(sched), 1'b1, 1'b1);
          endcase
        end
      endcase
      nk    = clamp_kw(cur_key_words);
      nkeys = $urandom_range(1, 4);
      // long hold-off on the result side while keys keep coming
      if (phase == 3) begin
        nkeys = 4;
        stall_request = 1'b1;
      end
      repeat (nkeys) begin
        if ($urandom_range(0, 5) == 0) send_random_key($urandom_range(1, nk - 1));
        else send_random_key(nk);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (expander.faults == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/aks_pkg.sv
hw/rtl/aks_if.sv
hw/rtl/aks_front.sv
hw/rtl/aks_queue.sv
hw/rtl/aks_back.sv
hw/rtl/aks_key_schedule_core.sv
tb/aes_key_schedule_core_test.sv
